### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LBB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/lbb_pkg.sv
// Types, codes and constants of the label bounding box table.
`default_nettype none

package lbb_pkg;

  localparam int LABEL_COUNT_DEF = 256;
  localparam int MAX_DIM         = 4096;
  localparam int CMD_DEPTH       = 4;
  localparam int RES_DEPTH       = 2;

  localparam logic [12:0] DIM_SAT = 13'(MAX_DIM);

  // reset values of the registers
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [7:0]  PATCH_RST  = 8'd7;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PATCH  = 2'd2;
  localparam logic [1:0] REG_FULL   = 2'd3;

  // input word kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // commands from the front end to the back end
  localparam logic [2:0] OP_PIXEL  = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_AREA   = 3'd2;
  localparam logic [2:0] OP_ABSENT = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  label;
  } in_word_t;

  typedef struct packed {
    logic        present;
    logic [11:0] x_min;
    logic [11:0] y_min;
    logic [12:0] x_max;
    logic [12:0] y_max;
  } out_word_t;

  typedef struct packed {
    logic [11:0] x_min;
    logic [11:0] y_min;
    logic [12:0] x_max;
    logic [12:0] y_max;
  } box_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  label;
    logic [11:0] x;
    logic [11:0] y;
  } cmd_t;

  // settings derived from the registers
  typedef struct packed {
    logic        full_mode;
    logic [12:0] x_limit;
    logic [12:0] y_limit;
  } cfg_t;

endpackage

`default_nettype wire

### src/label_bounding_box_table.sv
// Top level of the label bounding box table: registers, front end, queues, back end.
// Throughput: one word per cycle while the result queue has room for reads; box memory has one read
// and one write port per cycle, a pixel update forwards the last written box to the next word.
// A read result is registered in the command queue, the back-end command register and the result queue.
// Reset: registers return to 640 x 480, patch 7, full mode off; all labels unseen at once.
// The box memory is not cleared; no clearing pass, words are taken right after reset.
`default_nettype none

module label_bounding_box_table #(
  parameter int LABEL_COUNT = lbb_pkg::LABEL_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output      logic               full,
  input  wire lbb_pkg::in_word_t  in_data,
  input  wire logic               pop,
  output      logic               empty,
  output      lbb_pkg::out_word_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);

  logic [12:0] img_width_r;
  logic [12:0] img_height_r;
  logic [7:0]  patch_r;
  logic        full_mode_r;

  lbb_pkg::cfg_t      cfg;
  lbb_pkg::cmd_t      front_cmd;
  logic               front_keep;
  lbb_pkg::cmd_t      head_cmd;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               res_full;
  logic               res_push;
  lbb_pkg::out_word_t res_word;
  logic [12:0]        w_sat;
  logic [12:0]        h_sat;
  logic [12:0]        patch_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= lbb_pkg::WIDTH_RST;
      img_height_r <= lbb_pkg::HEIGHT_RST;
      patch_r      <= lbb_pkg::PATCH_RST;
      full_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbb_pkg::REG_WIDTH:  img_width_r  <= cfg_data;
        lbb_pkg::REG_HEIGHT: img_height_r <= cfg_data;
        lbb_pkg::REG_PATCH:  patch_r      <= cfg_data[7:0];
        lbb_pkg::REG_FULL:   full_mode_r  <= cfg_data[0];
      endcase
    end
  end

  // exclusive limit of the valid area, zero when the patch is zero or does not fit
  assign w_sat     = (img_width_r > lbb_pkg::DIM_SAT) ? lbb_pkg::DIM_SAT : img_width_r;
  assign h_sat     = (img_height_r > lbb_pkg::DIM_SAT) ? lbb_pkg::DIM_SAT : img_height_r;
  assign patch_ext = {5'd0, patch_r};

  always_comb begin
    cfg.full_mode = full_mode_r;
    cfg.x_limit   = (patch_r == '0 || patch_ext > w_sat) ? 13'd0 : w_sat - patch_ext + 13'd1;
    cfg.y_limit   = (patch_r == '0 || patch_ext > h_sat) ? 13'd0 : h_sat - patch_ext + 13'd1;
  end

  lbb_front #(
    .LABEL_COUNT(LABEL_COUNT)
  ) u_front (
    .in_word(in_data),
    .cfg    (cfg),
    .cmd    (front_cmd),
    .keep   (front_keep)
  );

  lbb_fifo #(
    .WIDTH($bits(lbb_pkg::cmd_t)),
    .DEPTH(lbb_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push && front_keep),
    .wdata(front_cmd),
    .full (full),
    .pop  (cmd_pop),
    .rdata(head_cmd),
    .empty(cmd_empty)
  );

  lbb_back #(
    .LABEL_COUNT(LABEL_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd      (head_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_word)
  );

  lbb_fifo #(
    .WIDTH($bits(lbb_pkg::out_word_t)),
    .DEPTH(lbb_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_word),
    .full (res_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule

`default_nettype wire

### src/lbb_fifo.sv
// Small register queue used between front and back and on the result side.
`default_nettype none

module lbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW:0]      wr_ptr_r;
  logic [AW:0]      rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]) && (wr_ptr_r[AW] != rd_ptr_r[AW]);
  assign rdata = slot_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r[AW-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

### src/lbb_front.sv
// Front end: sorts input words into back-end commands, drops ignored pixels and spare-kind words.
`default_nettype none

module lbb_front #(
  parameter int LABEL_COUNT = lbb_pkg::LABEL_COUNT_DEF
) (
  input  wire lbb_pkg::in_word_t in_word,
  input  wire lbb_pkg::cfg_t     cfg,
  output      lbb_pkg::cmd_t     cmd,
  output      logic              keep
);

  logic in_range;
  logic in_area;
  logic area_ok;

  assign in_range = (32'(in_word.label) < LABEL_COUNT);
  assign in_area  = ({1'b0, in_word.pos_x} < cfg.x_limit) &&
                    ({1'b0, in_word.pos_y} < cfg.y_limit);
  assign area_ok  = (cfg.x_limit != '0) && (cfg.y_limit != '0);

  always_comb begin
    cmd.label = in_word.label;
    cmd.x     = in_word.pos_x;
    cmd.y     = in_word.pos_y;
    cmd.op    = lbb_pkg::OP_ABSENT;
    keep      = 1'b0;
    unique case (in_word.kind)
      lbb_pkg::KIND_PIXEL: begin
        cmd.op = lbb_pkg::OP_PIXEL;
        keep   = !cfg.full_mode && in_range && in_area;
      end
      lbb_pkg::KIND_READ: begin
        keep = 1'b1;
        if (cfg.full_mode) begin
          // only label 0 exists in full mode, covering the valid area when there is one
          cmd.op = (in_word.label == '0 && area_ok) ? lbb_pkg::OP_AREA
                                                   : lbb_pkg::OP_ABSENT;
        end else begin
          cmd.op = in_range ? lbb_pkg::OP_LOOKUP : lbb_pkg::OP_ABSENT;
        end
      end
      lbb_pkg::KIND_CLEAR: begin
        cmd.op = lbb_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/lbb_back.sv
// Back end: box memory read-modify-write with forwarding, seen bits, result build.
`default_nettype none

module lbb_back #(
  parameter int LABEL_COUNT = lbb_pkg::LABEL_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lbb_pkg::cfg_t     cfg,
  input  wire logic              cmd_empty,
  input  wire lbb_pkg::cmd_t     cmd,
  output      logic              cmd_pop,
  input  wire logic              res_full,
  output      logic              res_push,
  output      lbb_pkg::out_word_t res
);

  localparam int IDX_W = $clog2(LABEL_COUNT);

  lbb_pkg::box_t    box_mem [LABEL_COUNT];
  lbb_pkg::box_t    rdata_r;
  lbb_pkg::cmd_t    b_cmd_r;
  logic             b_valid_r;
  logic [LABEL_COUNT-1:0] seen_r;
  logic             lw_valid_r;
  logic [IDX_W-1:0] lw_label_r;
  lbb_pkg::box_t    lw_box_r;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] head_idx;
  logic             is_read;
  logic             done;
  logic             advance;
  logic             wr_en;
  logic             seen;
  lbb_pkg::box_t    old_box;
  lbb_pkg::box_t    new_box;
  logic [12:0]      x_end;
  logic [12:0]      y_end;

  assign idx      = b_cmd_r.label[IDX_W-1:0];
  assign head_idx = cmd.label[IDX_W-1:0];
  assign is_read  = (b_cmd_r.op == lbb_pkg::OP_LOOKUP) || (b_cmd_r.op == lbb_pkg::OP_AREA) ||
                    (b_cmd_r.op == lbb_pkg::OP_ABSENT);
  assign done     = b_valid_r && (!is_read || !res_full);
  assign advance  = !b_valid_r || done;
  assign cmd_pop  = advance && !cmd_empty;
  assign wr_en    = done && (b_cmd_r.op == lbb_pkg::OP_PIXEL);
  assign res_push = done && is_read;
  assign seen     = seen_r[idx];

  // the memory was read at the edge the last write landed; take that word instead
  assign old_box = (lw_valid_r && lw_label_r == idx) ? lw_box_r : rdata_r;

  assign x_end = {1'b0, b_cmd_r.x} + 13'd1;
  assign y_end = {1'b0, b_cmd_r.y} + 13'd1;

  always_comb begin
    if (!seen) begin
      new_box.x_min = b_cmd_r.x;
      new_box.y_min = b_cmd_r.y;
      new_box.x_max = x_end;
      new_box.y_max = y_end;
    end else begin
      new_box.x_min = (b_cmd_r.x < old_box.x_min) ? b_cmd_r.x : old_box.x_min;
      new_box.y_min = (b_cmd_r.y < old_box.y_min) ? b_cmd_r.y : old_box.y_min;
      new_box.x_max = (x_end > old_box.x_max) ? x_end : old_box.x_max;
      new_box.y_max = (y_end > old_box.y_max) ? y_end : old_box.y_max;
    end
  end

  always_comb begin
    res = '0;
    if (b_cmd_r.op == lbb_pkg::OP_AREA) begin
      res.present = 1'b1;
      res.x_max   = cfg.x_limit;
      res.y_max   = cfg.y_limit;
    end else if (b_cmd_r.op == lbb_pkg::OP_LOOKUP && seen) begin
      res.present = 1'b1;
      res.x_min   = old_box.x_min;
      res.y_min   = old_box.y_min;
      res.x_max   = old_box.x_max;
      res.y_max   = old_box.y_max;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_mem[idx] <= new_box;
    end
    if (cmd_pop) begin
      rdata_r <= box_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      b_cmd_r <= cmd;
    end
    if (wr_en) begin
      lw_label_r <= idx;
      lw_box_r   <= new_box;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      lw_valid_r <= 1'b0;
      seen_r     <= '0;
    end else begin
      if (advance) begin
        b_valid_r <= !cmd_empty;
      end
      if (done) begin
        lw_valid_r <= wr_en;
      end
      if (wr_en) begin
        seen_r[idx] <= 1'b1;
      end else if (done && b_cmd_r.op == lbb_pkg::OP_CLEAR) begin
        seen_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### src/lbb_checker.sv
// Port-level checks on the result side, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lbb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               pop,
  input wire logic               empty,
  input wire lbb_pkg::out_word_t out_data
);

  logic absent_w;
  logic present_w;
  logic hold_w;
  logic box_zero;
  logic box_ok;

  assign absent_w  = !empty && !out_data.present;
  assign present_w = !empty && out_data.present;
  assign hold_w    = !empty && !pop;
  assign box_zero  = (out_data.x_min == 12'd0) && (out_data.y_min == 12'd0) &&
                     (out_data.x_max == 13'd0) && (out_data.y_max == 13'd0);
  assign box_ok    = (13'(out_data.x_min) < out_data.x_max) &&
                     (13'(out_data.y_min) < out_data.y_max) &&
                     (out_data.x_max <= 13'd4096) && (out_data.y_max <= 13'd4096);

  // nothing waits at the first edge out of reset
  `LBB_ASSERT_ALWAYS(a_empty_after_reset, clk, rst_n && $past(!rst_n) |-> empty, "word after reset")

  // an absent label carries an all-zero box
  `LBB_ASSERT_RST(a_absent_zero, clk, rst_n, absent_w |-> box_zero, "absent word not zero")

  // a present box is non-empty and ends within 4096 on each axis
  `LBB_ASSERT_RST(a_box_order, clk, rst_n, present_w |-> box_ok, "bad box corners")

  // a waiting word holds until popped
  `LBB_ASSERT_RST(a_word_holds, clk, rst_n, hold_w |=> (!empty && $stable(out_data)), "word moved")

endmodule

bind label_bounding_box_table lbb_checker u_lbb_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .pop     (pop),
  .empty   (empty),
  .out_data(out_data)
);

`default_nettype wire

### sim/tb_label_bounding_box_table.sv
// Self-checking bench for the label bounding box table: queued stimulus, box predictor, result check.
module tb_label_bounding_box_table;
  import lbb_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         PRINT_CAP = 50;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_data = '0;
  logic      pop = 1'b0;
  logic      empty;
  out_word_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [12:0] cfg_data = '0;

  label_bounding_box_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [12:0] cfg_width  = WIDTH_RST;
  logic [12:0] cfg_height = HEIGHT_RST;
  logic [7:0]  cfg_patch  = PATCH_RST;
  logic        cfg_full   = 1'b0;
  bit          box_seen [256];
  box_t        box_tab [256];

  in_word_t  pending_words [$];
  out_word_t expected_boxes [$];
  int        words_queued = 0;
  int        words_taken = 0;
  int        fault_count = 0;
  int        cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        in_idle_on = 1'b1;
  bit        out_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fault_count++;
    if (fault_count <= PRINT_CAP)
      $display("mismatch %s at cycle %0d: got %0d, want %0d", what, cycles, got, want);
  endtask

  // exclusive limit of the valid area along one axis, 0 when there is none
  function automatic int axis_limit(input logic [12:0] dim);
    int d;
    d = (dim > 13'd4096) ? 4096 : int'(dim);
    if (cfg_patch == 8'd0 || int'(cfg_patch) > d)
      return 0;
    return d - int'(cfg_patch) + 1;
  endfunction

  task automatic update_boxes(input in_word_t w);
    int        xl;
    int        yl;
    box_t      b;
    out_word_t r;
    xl = axis_limit(cfg_width);
    yl = axis_limit(cfg_height);
    case (w.kind)
      KIND_PIXEL: begin
        if (!cfg_full && w.pos_x < xl && w.pos_y < yl) begin
          b = box_tab[w.label];
          if (!box_seen[w.label]) begin
            b.x_min = w.pos_x;
            b.y_min = w.pos_y;
            b.x_max = 13'(w.pos_x) + 13'd1;
            b.y_max = 13'(w.pos_y) + 13'd1;
            box_seen[w.label] = 1'b1;
          end else begin
            if (w.pos_x < b.x_min) b.x_min = w.pos_x;
            if (w.pos_y < b.y_min) b.y_min = w.pos_y;
            if (13'(w.pos_x) + 13'd1 > b.x_max) b.x_max = 13'(w.pos_x) + 13'd1;
            if (13'(w.pos_y) + 13'd1 > b.y_max) b.y_max = 13'(w.pos_y) + 13'd1;
          end
          box_tab[w.label] = b;
        end
      end
      KIND_READ: begin
        r = '0;
        if (cfg_full) begin
          if (w.label == 8'd0 && xl != 0 && yl != 0) begin
            r.present = 1'b1;
            r.x_max   = 13'(xl);
            r.y_max   = 13'(yl);
          end
        end else if (box_seen[w.label]) begin
          b = box_tab[w.label];
          r.present = 1'b1;
          r.x_min   = b.x_min;
          r.y_min   = b.y_min;
          r.x_max   = b.x_max;
          r.y_max   = b.y_max;
        end
        expected_boxes.push_back(r);
      end
      KIND_CLEAR: box_seen = '{default: 1'b0};
      default: ;
    endcase
  endtask

  task automatic check_box(input out_word_t got);
    out_word_t want;
    if (expected_boxes.size() == 0) begin
      report("unexpected word", 32'(got.present), 32'd0);
    end else begin
      want = expected_boxes.pop_front();
      if (got.present !== want.present)
        report("present", 32'(got.present), 32'(want.present));
      if (got.x_min !== want.x_min) report("x_min", 32'(got.x_min), 32'(want.x_min));
      if (got.y_min !== want.y_min) report("y_min", 32'(got.y_min), 32'(want.y_min));
      if (got.x_max !== want.x_max) report("x_max", 32'(got.x_max), 32'(want.x_max));
      if (got.y_max !== want.y_max) report("y_max", 32'(got.y_max), 32'(want.y_max));
    end
  endtask

  // input side: holds the word while full, idles in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        update_boxes(in_data);
        words_taken++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (in_gap != 0) begin
        push   <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (in_idle_on && $urandom_range(0, 7) == 0) begin
        push   <= 1'b0;
        in_gap <= $urandom_range(0, 14);
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        push    <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        check_box(out_data);
      if (out_gap != 0) begin
        pop     <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        pop     <= 1'b0;
        out_gap <= $urandom_range(0, 14);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic in_word_t make_word(input logic [1:0] kind, input int x, input int y,
                                         input int lab);
    in_word_t w;
    w.kind  = kind;
    w.pos_x = 12'(x);
    w.pos_y = 12'(y);
    w.label = 8'(lab);
    return w;
  endfunction

  task automatic queue_word(input logic [1:0] kind, input int x, input int y, input int lab);
    pending_words.push_back(make_word(kind, x, y, lab));
    words_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width  = val;
      REG_HEIGHT: cfg_height = val;
      REG_PATCH:  cfg_patch  = val[7:0];
      REG_FULL:   cfg_full   = val[0];
      default: ;
    endcase
  endtask

  // unused upper bits of the write data are junk on purpose
  task automatic setup(input logic [12:0] w, input logic [12:0] h, input logic [7:0] p,
                       input logic f);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PATCH, {5'($urandom), p});
    write_reg(REG_FULL, {12'($urandom), f});
  endtask

  // block idle: every word taken, every box back, pixel updates flushed
  task automatic settle();
    while (words_taken != words_queued) @(posedge clk);
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_coord(input int lim);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0 || lim == 0) return $urandom_range(0, 4095);
    if (sel == 1) return (lim > 4095) ? 4095 : lim;
    if (sel == 2) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 8191));
      1: return 13'd8191;
      2: return 13'd4096;
      default: return 13'($urandom_range(16, 4096));
    endcase
  endfunction

  function automatic int pick_label();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
  endfunction

  task automatic queue_random(input int n);
    int xl;
    int yl;
    int r;
    xl = axis_limit(cfg_width);
    yl = axis_limit(cfg_height);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        queue_word(KIND_PIXEL, pick_coord(xl), pick_coord(yl), pick_label());
      else if (r < 95)
        queue_word(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 4095), pick_label());
      else if (r < 97)
        queue_word(KIND_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095), pick_label());
      else
        queue_word(KIND_SPARE, $urandom_range(0, 4095), $urandom_range(0, 4095), pick_label());
    end
  endtask

  initial begin
    logic [7:0] p;
    box_seen = '{default: 1'b0};
    box_tab  = '{default: '0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: valid area is 634 x 474
    queue_word(KIND_READ, 0, 0, 5);
    queue_word(KIND_PIXEL, 0, 0, 0);
    queue_word(KIND_READ, 0, 0, 0);
    queue_word(KIND_PIXEL, 633, 473, 0);
    queue_word(KIND_PIXEL, 634, 10, 0);
    queue_word(KIND_PIXEL, 10, 474, 0);
    queue_word(KIND_PIXEL, 4095, 4095, 255);
    queue_word(KIND_READ, 0, 0, 0);
    queue_word(KIND_READ, 0, 0, 255);
    // back-to-back updates of one label exercise forwarding
    queue_word(KIND_PIXEL, 300, 200, 255);
    queue_word(KIND_PIXEL, 100, 250, 255);
    queue_word(KIND_PIXEL, 350, 150, 255);
    queue_word(KIND_READ, 0, 0, 255);
    queue_word(KIND_SPARE, 4095, 4095, 255);
    queue_word(KIND_CLEAR, 0, 0, 0);
    queue_word(KIND_READ, 0, 0, 255);
    queue_word(KIND_READ, 0, 0, 0);
    queue_word(KIND_PIXEL, 5, 6, 255);
    queue_word(KIND_READ, 0, 0, 255);
    settle();

    // full mode hides the stored boxes but keeps them
    setup(WIDTH_RST, HEIGHT_RST, PATCH_RST, 1'b1);
    queue_word(KIND_READ, 0, 0, 0);
    queue_word(KIND_READ, 0, 0, 255);
    queue_word(KIND_PIXEL, 1, 1, 255);
    settle();
    setup(WIDTH_RST, HEIGHT_RST, PATCH_RST, 1'b0);
    queue_word(KIND_READ, 0, 0, 255);
    settle();

    // oversized width saturates, patch 1 opens the whole grid
    setup(13'd8191, 13'd4096, 8'd1, 1'b0);
    queue_word(KIND_PIXEL, 4095, 4095, 7);
    queue_word(KIND_PIXEL, 0, 0, 7);
    queue_word(KIND_READ, 0, 0, 7);
    settle();
    setup(13'd8191, 13'd4096, 8'd1, 1'b1);
    queue_word(KIND_READ, 0, 0, 0);
    settle();

    // no valid area: zero patch, patch wider than the image, zero width
    setup(13'd100, 13'd100, 8'd0, 1'b0);
    queue_word(KIND_PIXEL, 1, 1, 9);
    queue_word(KIND_READ, 0, 0, 9);
    settle();
    setup(13'd100, 13'd100, 8'd255, 1'b1);
    queue_word(KIND_READ, 0, 0, 0);
    settle();
    setup(13'd0, 13'd100, 8'd1, 1'b1);
    queue_word(KIND_READ, 0, 0, 0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0: p = 8'd0;
        1: p = 8'($urandom_range(0, 255));
        default: p = 8'($urandom_range(1, 16));
      endcase
      setup(pick_dim(), pick_dim(), p, $urandom_range(0, 5) == 0);
      in_idle_on  = (ph != 9) && ($urandom_range(0, 3) != 0);
      out_idle_on = (ph != 9) && ($urandom_range(0, 3) != 0);
      queue_random(80);
      settle();
    end

    if (fault_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
